// ===== rtl/ppc_pkg.sv =====
// Shared types and constants of the PI pose controller.
package ppc_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned INTEG_W = 48;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned ROOT_W = 33;

    localparam logic signed [DATA_W-1:0] PI_Q = 32'sd205887;
    localparam logic signed [DATA_W-1:0] TWO_PI_Q = 32'sd411775;

    localparam logic signed [DATA_W-1:0] TURN_KP_DEFAULT = 32'sd65536;
    localparam logic signed [DATA_W-1:0] TURN_KI_DEFAULT = 32'sd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_DISTANCE = 3'd0,
        REG_TARGET_ANGLE    = 3'd1,
        REG_POSITION_TOL    = 3'd2,
        REG_ANGLE_TOL       = 3'd3,
        REG_SPEED_LIMIT     = 3'd4,
        REG_TURN_RATE_LIMIT = 3'd5,
        REG_DISTANCE_KP     = 3'd6,
        REG_DISTANCE_KI     = 3'd7
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQUARE,
        ST_ROOT,
        ST_GOAL,
        ST_LATCH,
        ST_DIST_ERR,
        ST_DIST_INT,
        ST_DIST_CMD,
        ST_HEAD_ERR,
        ST_HEAD_INT,
        ST_HEAD_CMD,
        ST_FINISH,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic load;
        logic restart;
        logic diff;
        logic square;
        logic root_init;
        logic root_step;
        logic goal;
        logic latch;
        logic dist_err;
        logic dist_int;
        logic dist_cmd;
        logic head_err;
        logic head_int;
        logic head_cmd;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic root_done;
        logic goal_met;
        logic started;
        logic dist_active;
    } dp_status_t;

endpackage

// ===== rtl/pi_pose_controller.sv =====
// Top level of the PI pose controller.
// A pose beat runs the difference, square, 33-step square root and goal test, then
// a start-pose latch on a first beat, the distance loop unless it is skipped and the
// heading loop; a met goal goes straight to the result. One beat in flight: no new
// pose beat is accepted until the result is taken. A restart beat gives no result.
// Reset (aresetn low, synchronous) restores register defaults and clears pose state.
module pi_pose_controller #(
    parameter logic signed [ppc_pkg::DATA_W-1:0] TURN_KP = ppc_pkg::TURN_KP_DEFAULT,
    parameter logic signed [ppc_pkg::DATA_W-1:0] TURN_KI = ppc_pkg::TURN_KI_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // pos_x, pos_y, heading, timestamp
    input  logic         s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // speed_command, turn_command
    output logic         m_tuser,   // goal_reached
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [ppc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]  cfg_data
);
    import ppc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       busy;
    logic       result_valid;
    logic       in_beat;
    logic signed [DATA_W-1:0] speed, turn;
    logic       reached;

    assign s_tready  = !busy;
    assign in_beat   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    ppc_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_beat      (in_beat),
        .in_restart   (s_tuser),
        .out_free     (m_tready),
        .status       (status),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid)
    );

    ppc_datapath #(
        .TURN_KP (TURN_KP),
        .TURN_KI (TURN_KI)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .in_x        (s_tdata[31:0]),
        .in_y        (s_tdata[63:32]),
        .in_h        (s_tdata[95:64]),
        .in_t        (s_tdata[127:96]),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_idx     (cfg_index),
        .cfg_data    (cfg_data),
        .speed_out   (speed),
        .turn_out    (turn),
        .reached_out (reached)
    );

    assign m_tvalid = result_valid;
    assign m_tdata  = {turn, speed};
    assign m_tuser  = reached;

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input accepted while a result waits");
    a_result_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=> !m_tvalid)
        else $error("result repeated");
    a_reached_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("goal result carries nonzero command");

endmodule

// ===== rtl/ppc_ctrl.sv =====
// Sequencer of the PI pose controller.
module ppc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_beat,
    input  logic                in_restart,
    input  logic                out_free,
    input  ppc_pkg::dp_status_t status,
    output ppc_pkg::dp_cmd_t    cmd,
    output logic                busy,
    output logic                result_valid
);
    import ppc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_beat && !in_restart) begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:   state_next = ST_SQUARE;
            ST_SQUARE: state_next = ST_ROOT;
            ST_ROOT: begin
                if (status.root_done) begin
                    state_next = ST_GOAL;
                end
            end
            ST_GOAL: begin
                if (status.goal_met) begin
                    state_next = ST_OUTPUT;
                end else if (!status.started) begin
                    state_next = ST_LATCH;
                end else if (status.dist_active) begin
                    state_next = ST_DIST_ERR;
                end else begin
                    state_next = ST_HEAD_ERR;
                end
            end
            ST_LATCH: begin
                if (status.dist_active) begin
                    state_next = ST_DIST_ERR;
                end else begin
                    state_next = ST_HEAD_ERR;
                end
            end
            ST_DIST_ERR: state_next = ST_DIST_INT;
            ST_DIST_INT: state_next = ST_DIST_CMD;
            ST_DIST_CMD: state_next = ST_HEAD_ERR;
            ST_HEAD_ERR: state_next = ST_HEAD_INT;
            ST_HEAD_INT: state_next = ST_HEAD_CMD;
            ST_HEAD_CMD: state_next = ST_FINISH;
            ST_FINISH:   state_next = ST_OUTPUT;
            ST_OUTPUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        busy = (state_reg != ST_IDLE);
        result_valid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cmd.load = in_beat && !in_restart;
                cmd.restart = in_beat && in_restart;
            end
            ST_DIFF:     cmd.diff = 1'b1;
            ST_SQUARE: begin
                cmd.square = 1'b1;
                cmd.root_init = 1'b1;
            end
            ST_ROOT:     cmd.root_step = 1'b1;
            ST_GOAL:     cmd.goal = 1'b1;
            ST_LATCH:    cmd.latch = 1'b1;
            ST_DIST_ERR: cmd.dist_err = 1'b1;
            ST_DIST_INT: cmd.dist_int = 1'b1;
            ST_DIST_CMD: cmd.dist_cmd = 1'b1;
            ST_HEAD_ERR: cmd.head_err = 1'b1;
            ST_HEAD_INT: cmd.head_int = 1'b1;
            ST_HEAD_CMD: cmd.head_cmd = 1'b1;
            ST_FINISH:   cmd.finish = 1'b1;
            ST_OUTPUT:   result_valid = 1'b1;
            default:     cmd = '0;
        endcase
    end

endmodule

// ===== rtl/ppc_datapath.sv =====
// Datapath of the PI pose controller: pose state, distance root, PI loops.
module ppc_datapath #(
    parameter logic signed [ppc_pkg::DATA_W-1:0] TURN_KP = ppc_pkg::TURN_KP_DEFAULT,
    parameter logic signed [ppc_pkg::DATA_W-1:0] TURN_KI = ppc_pkg::TURN_KI_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ppc_pkg::dp_cmd_t                    cmd,
    output ppc_pkg::dp_status_t                 status,
    input  logic signed [ppc_pkg::DATA_W-1:0]   in_x,
    input  logic signed [ppc_pkg::DATA_W-1:0]   in_y,
    input  logic signed [ppc_pkg::DATA_W-1:0]   in_h,
    input  logic        [ppc_pkg::DATA_W-1:0]   in_t,
    input  logic                                cfg_we,
    input  logic        [ppc_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic        [ppc_pkg::DATA_W-1:0]   cfg_data,
    output logic signed [ppc_pkg::DATA_W-1:0]   speed_out,
    output logic signed [ppc_pkg::DATA_W-1:0]   turn_out,
    output logic                                reached_out
);
    import ppc_pkg::*;

    localparam int unsigned CMD_W = 64;
    localparam logic signed [INTEG_W-1:0] I48_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] I48_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    // configuration
    logic signed [DATA_W-1:0] tdist_reg, tang_reg, slim_reg, tlim_reg, kp_reg, ki_reg;
    logic        [DATA_W-2:0] ptol_reg, atol_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tdist_reg <= '0;
            tang_reg  <= '0;
            ptol_reg  <= 31'd6554;
            atol_reg  <= 31'd6554;
            slim_reg  <= 32'sd65536;
            tlim_reg  <= 32'sd65536;
            kp_reg    <= 32'sd65536;
            ki_reg    <= '0;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_idx))
                REG_TARGET_DISTANCE: tdist_reg <= cfg_data;
                REG_TARGET_ANGLE:    tang_reg  <= cfg_data;
                REG_POSITION_TOL:    ptol_reg  <= cfg_data[DATA_W-2:0];
                REG_ANGLE_TOL:       atol_reg  <= cfg_data[DATA_W-2:0];
                REG_SPEED_LIMIT:     slim_reg  <= cfg_data;
                REG_TURN_RATE_LIMIT: tlim_reg  <= cfg_data;
                REG_DISTANCE_KP:     kp_reg    <= cfg_data;
                REG_DISTANCE_KI:     ki_reg    <= cfg_data;
                default:             tdist_reg <= tdist_reg;
            endcase
        end
    end

    // pose state
    logic                     started_reg;
    logic signed [DATA_W-1:0] sx_reg, sy_reg, sh_reg, px_reg, py_reg, ph_reg;
    logic        [DATA_W-1:0] pt_reg;
    logic signed [INTEG_W-1:0] dint_reg, hint_reg;

    // sample
    logic signed [DATA_W-1:0] x_reg, y_reg, h_reg;
    logic        [DATA_W-1:0] t_reg;

    // distance
    logic [DATA_W:0]       ax_reg, ay_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [2*ROOT_W-1:0]   rem_reg;
    logic [5:0]            bit_reg;

    logic signed [ROOT_W+1:0] sd;
    logic signed [DATA_W-1:0] err_reg;
    logic signed [DATA_W-1:0] dt_reg;
    logic signed [CMD_W-1:0]  speed_reg, turn_reg;
    logic signed [CMD_W-1:0]  prod_reg;
    logic signed [DATA_W-1:0] speed_out_reg, turn_out_reg;
    logic                     reached_reg;
    logic signed [DATA_W+1:0] hu_reg;

    logic signed [DATA_W:0] dx, dy;
    assign dx = $signed({x_reg[DATA_W-1], x_reg}) - $signed({sx_reg[DATA_W-1], sx_reg});
    assign dy = $signed({y_reg[DATA_W-1], y_reg}) - $signed({sy_reg[DATA_W-1], sy_reg});

    // bit-by-bit root: test (2*root + bit)*bit against remainder
    logic [2*ROOT_W-1:0] trial;
    logic [2*ROOT_W-1:0] bitsq;
    logic [ROOT_W-1:0]   bitv;
    assign bitv  = ROOT_W'(1) << bit_reg;
    assign bitsq = (2*ROOT_W)'(1) << {bit_reg, 1'b0};
    assign trial = ({{ROOT_W{1'b0}}, root_reg} << (bit_reg + 6'd1)) + bitsq;

    // signed distance from the settled root
    assign sd = tdist_reg[DATA_W-1] ? -$signed({2'b00, root_reg}) : $signed({2'b00, root_reg});

    // goal test
    logic signed [ROOT_W+2:0] derr;
    logic signed [DATA_W+2:0] aerr, aerr_p, aerr_m;
    logic signed [DATA_W+2:0] tdist_abs;
    logic                     pos_ok, ang_ok;

    function automatic logic signed [DATA_W+2:0] absv(input logic signed [DATA_W+2:0] v);
        begin
            absv = v[DATA_W+2] ? -v : v;
        end
    endfunction

    always_comb begin
        derr   = (ROOT_W+3)'(sd) - (ROOT_W+3)'(tdist_reg);
        aerr   = (DATA_W+3)'(tang_reg) - ((DATA_W+3)'(h_reg) - (DATA_W+3)'(sh_reg));
        aerr_p = aerr + (DATA_W+3)'(TWO_PI_Q);
        aerr_m = aerr - (DATA_W+3)'(TWO_PI_Q);
        pos_ok = ((derr[ROOT_W+2] ? -derr : derr) <= (ROOT_W+3)'($signed({1'b0, ptol_reg})));
        ang_ok = (absv(aerr) <= (DATA_W+3)'($signed({1'b0, atol_reg})))
              || (absv(aerr_p) <= (DATA_W+3)'($signed({1'b0, atol_reg})))
              || (absv(aerr_m) <= (DATA_W+3)'($signed({1'b0, atol_reg})));
        tdist_abs = absv((DATA_W+3)'(tdist_reg));
    end

    // shared multiplier: floor(k*v/2^16) = k*v_hi + floor(k*v_lo/2^16)
    logic signed [DATA_W-1:0]  mk;
    logic signed [INTEG_W-1:0] mv;
    logic signed [DATA_W-1:0]  mvh;
    logic        [15:0]        mvl;
    logic signed [2*DATA_W-1:0] mhi;
    logic signed [DATA_W+16:0]  mlo;
    logic signed [CMD_W-1:0]   mres;
    assign mvh  = mv[INTEG_W-1:16];
    assign mvl  = mv[15:0];
    assign mhi  = mk * mvh;
    assign mlo  = mk * $signed({1'b0, mvl});
    assign mres = mhi + CMD_W'(mlo >>> 16);

    logic signed [DATA_W-1:0] e_sat;
    logic signed [DATA_W+2:0] e_wide;
    logic signed [DATA_W+2:0] hadj;
    logic signed [DATA_W+2:0] hdiff;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [CMD_W-1:0] v);
        begin
            if (v > CMD_W'(32'sh7FFFFFFF)) begin
                sat32 = 32'sh7FFFFFFF;
            end else if (v < -CMD_W'(33'sh080000000)) begin
                sat32 = 32'sh80000000;
            end else begin
                sat32 = v[DATA_W-1:0];
            end
        end
    endfunction

    logic signed [INTEG_W+1:0] int_sum;
    logic signed [INTEG_W-1:0] int_cur;
    logic signed [INTEG_W-1:0] int_sat;

    always_comb begin
        mk = err_reg;
        mv = INTEG_W'(dt_reg);
        if (cmd.dist_int || cmd.head_int) begin
            mk = err_reg;
            mv = $signed({{(INTEG_W-DATA_W){1'b0}}, dt_reg});
        end else if (cmd.dist_cmd) begin
            mk = ki_reg;
            mv = dint_reg;
        end else if (cmd.head_cmd) begin
            mk = TURN_KI;
            mv = hint_reg;
        end
        int_cur = cmd.head_int ? hint_reg : dint_reg;
        int_sum = (INTEG_W+2)'(int_cur) + $signed(mres[INTEG_W+1:0]);
        if (int_sum > (INTEG_W+2)'(I48_MAX)) begin
            int_sat = I48_MAX;
        end else if (int_sum < (INTEG_W+2)'(I48_MIN)) begin
            int_sat = I48_MIN;
        end else begin
            int_sat = int_sum[INTEG_W-1:0];
        end
        hdiff = (DATA_W+3)'(h_reg) - (DATA_W+3)'(ph_reg);
        if (hdiff < -(DATA_W+3)'(PI_Q)) begin
            hadj = (DATA_W+3)'(h_reg) + (DATA_W+3)'(TWO_PI_Q);
        end else if (hdiff > (DATA_W+3)'(PI_Q)) begin
            hadj = (DATA_W+3)'(h_reg) - (DATA_W+3)'(TWO_PI_Q);
        end else begin
            hadj = (DATA_W+3)'(h_reg);
        end
        if (cmd.dist_err) begin
            e_wide = (DATA_W+3)'(tdist_reg) - (DATA_W+3)'(sd);
        end else begin
            e_wide = (DATA_W+3)'(tang_reg) - (hadj - (DATA_W+3)'(sh_reg));
        end
        e_sat = sat32(CMD_W'(e_wide));
    end

    // kp*err product, separate multiplier (32x32)
    logic signed [DATA_W-1:0]   pk;
    logic signed [2*DATA_W-1:0] pprod;
    assign pk    = cmd.dist_err ? kp_reg : TURN_KP;
    assign pprod = pk * e_sat;

    logic signed [CMD_W-1:0] cmd_sum;
    logic signed [CMD_W-1:0] sp_cl, tn_cl;
    assign cmd_sum = prod_reg + mres;
    always_comb begin
        sp_cl = (speed_reg > CMD_W'(slim_reg)) ? CMD_W'(slim_reg) : speed_reg;
        tn_cl = (turn_reg > CMD_W'(tlim_reg)) ? CMD_W'(tlim_reg) : turn_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
            sx_reg <= '0; sy_reg <= '0; sh_reg <= '0;
            px_reg <= '0; py_reg <= '0; ph_reg <= '0;
            pt_reg <= '0;
            dint_reg <= '0; hint_reg <= '0;
            bit_reg <= '0;
        end else begin
            if (cmd.restart) begin
                started_reg <= 1'b0;
                sx_reg <= '0; sy_reg <= '0; sh_reg <= '0;
                px_reg <= '0; py_reg <= '0; ph_reg <= '0;
                pt_reg <= '0;
                dint_reg <= '0; hint_reg <= '0;
            end
            if (cmd.latch) begin
                started_reg <= 1'b1;
                sx_reg <= x_reg; sy_reg <= y_reg; sh_reg <= h_reg;
                px_reg <= x_reg; py_reg <= y_reg; ph_reg <= h_reg;
                pt_reg <= t_reg;
            end
            if (cmd.root_init) begin
                bit_reg <= 6'(ROOT_W-1);
            end else if (cmd.root_step && bit_reg != '0) begin
                bit_reg <= bit_reg - 6'd1;
            end
            if (cmd.dist_int) begin
                dint_reg <= int_sat;
            end
            if (cmd.head_int) begin
                hint_reg <= int_sat;
            end
            if (cmd.finish) begin
                px_reg <= x_reg;
                py_reg <= y_reg;
                ph_reg <= sat32(CMD_W'(hu_reg));
                pt_reg <= t_reg;
            end
        end
    end

    // one root bit per cycle until bit zero
    logic root_last;
    assign root_last = (bit_reg == '0);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg <= in_x;
            y_reg <= in_y;
            h_reg <= in_h;
            t_reg <= in_t;
        end
        if (cmd.diff) begin
            ax_reg <= dx[DATA_W] ? (DATA_W+1)'(-dx) : (DATA_W+1)'(dx);
            ay_reg <= dy[DATA_W] ? (DATA_W+1)'(-dy) : (DATA_W+1)'(dy);
        end
        if (cmd.square) begin
            root_reg <= '0;
        end
        if (cmd.root_init) begin
            rem_reg <= (2*ROOT_W)'(ax_reg) * (2*ROOT_W)'(ax_reg)
                     + (2*ROOT_W)'(ay_reg) * (2*ROOT_W)'(ay_reg);
        end
        if (cmd.root_step) begin
            if (trial <= rem_reg) begin
                rem_reg  <= rem_reg - trial;
                root_reg <= root_reg | bitv;
            end
        end
        if (cmd.goal) begin
            reached_reg <= pos_ok && ang_ok;
            speed_reg   <= '0;
            turn_reg    <= '0;
            if (pos_ok && ang_ok) begin
                speed_out_reg <= '0;
                turn_out_reg  <= '0;
            end
            dt_reg <= t_reg - pt_reg;
        end
        if (cmd.latch) begin
            dt_reg   <= '0;
            root_reg <= '0;
        end
        if (cmd.dist_err || cmd.head_err) begin
            err_reg  <= e_sat;
            prod_reg <= CMD_W'(pprod >>> 16);
            hu_reg   <= hadj[DATA_W+1:0];
        end
        if (cmd.dist_cmd) begin
            speed_reg <= cmd_sum;
        end
        if (cmd.head_cmd) begin
            turn_reg <= cmd_sum;
        end
        if (cmd.finish) begin
            speed_out_reg <= sat32(sp_cl);
            turn_out_reg  <= sat32(tn_cl);
            reached_reg   <= 1'b0;
        end
    end

    assign status.root_done   = root_last;
    assign status.goal_met    = pos_ok && ang_ok;
    assign status.started     = started_reg;
    assign status.dist_active = tdist_abs > (DATA_W+3)'($signed({1'b0, ptol_reg}));

    assign speed_out   = speed_out_reg;
    assign turn_out    = turn_out_reg;
    assign reached_out = reached_reg;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench of pi_pose_controller: random and directed pose beats against a predictor.
`timescale 1ns / 1ps

module tb;
    import ppc_pkg::*;

    typedef struct {
        bit        kind;
        bit [31:0] px;
        bit [31:0] py;
        bit [31:0] hd;
        bit [31:0] ts;
    } pose_beat_t;

    typedef struct {
        bit [31:0] speed;
        bit [31:0] turn;
        bit        reached;
    } command_t;

    localparam longint PI_V = 205887;
    localparam longint TWO_PI_V = 411775;
    localparam longint I48_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint I48_LO = -I48_HI - 1;
    localparam int WATCHDOG_LIMIT = 40000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;   // pos_x, pos_y, heading, timestamp
    logic         s_tuser = 1'b0; // kind
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;        // speed_command, turn_command
    logic         m_tuser;        // goal_reached
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    pi_pose_controller uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    pose_beat_t pending_beats[$];
    command_t   expected_cmds[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_send = 1'b0;
    int errors = 0;
    int n_goal = 0, n_cmd = 0, n_restart = 0, n_checked = 0;

    longint tgt_dist = 0, tgt_ang = 0, pos_tol = 6554, ang_tol = 6554;
    longint spd_lim = 65536, trn_lim = 65536, dist_kp = 65536, dist_ki = 0;
    bit     started = 1'b0;
    longint st_x = 0, st_y = 0, st_h = 0, last_x = 0, last_y = 0, last_h = 0;
    bit [31:0] last_t = '0;
    longint dist_int = 0, head_int = 0;

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint sat32(longint v);
        return sat(v, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function automatic longint abs_l(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint scale_q16(longint k, longint v);
        logic signed [127:0] a, b, p;
        a = k;
        b = v;
        p = a * b;
        p = p >>> 16;
        return p[63:0];
    endfunction

    function automatic longint travel(longint x, longint y, longint sx, longint sy);
        logic [65:0] a, b, s, t, r;
        a = abs_l(x - sx);
        b = abs_l(y - sy);
        s = a * a + b * b;
        r = '0;
        for (int i = 32; i >= 0; i--) begin
            t = r | (66'd1 << i);
            if (t * t <= s) r = t;
        end
        return longint'(r);
    endfunction

    task automatic advance_pose(pose_beat_t bt);
        longint x, y, h, sgn, sd, e, err, speed, turn;
        bit [31:0] dt;
        command_t c;
        if (bt.kind) begin
            started = 1'b0;
            st_x = 0; st_y = 0; st_h = 0;
            last_x = 0; last_y = 0; last_h = 0;
            last_t = '0;
            dist_int = 0; head_int = 0;
            n_restart++;
            return;
        end
        x = longint'(signed'(bt.px));
        y = longint'(signed'(bt.py));
        h = longint'(signed'(bt.hd));
        sgn = tgt_dist < 0 ? -1 : 1;
        sd = travel(x, y, st_x, st_y) * sgn;
        e = tgt_ang - (h - st_h);
        if (abs_l(sd - tgt_dist) <= pos_tol && (abs_l(e) <= ang_tol ||
                abs_l(e + TWO_PI_V) <= ang_tol || abs_l(e - TWO_PI_V) <= ang_tol)) begin
            c.speed = '0;
            c.turn = '0;
            c.reached = 1'b1;
            expected_cmds.push_back(c);
            n_goal++;
            return;
        end
        if (!started) begin
            st_x = x; last_x = x;
            st_y = y; last_y = y;
            st_h = h; last_h = h;
            last_t = bt.ts;
            started = 1'b1;
        end
        dt = bt.ts - last_t;
        speed = 0;
        if (abs_l(tgt_dist) > pos_tol) begin
            sd = travel(x, y, st_x, st_y) * sgn;
            err = sat32(tgt_dist - sd);
            dist_int = sat(dist_int + scale_q16(err, longint'(dt)), I48_LO, I48_HI);
            speed = scale_q16(dist_kp, err) + scale_q16(dist_ki, dist_int);
        end
        if (h - last_h < -PI_V) h += TWO_PI_V;
        else if (h - last_h > PI_V) h -= TWO_PI_V;
        err = sat32(tgt_ang - (h - st_h));
        head_int = sat(head_int + scale_q16(err, longint'(dt)), I48_LO, I48_HI);
        turn = scale_q16(longint'(TURN_KP_DEFAULT), err)
             + scale_q16(longint'(TURN_KI_DEFAULT), head_int);
        last_x = x;
        last_y = y;
        last_h = sat32(h);
        last_t = bt.ts;
        if (speed > spd_lim) speed = spd_lim;
        if (turn > trn_lim) turn = trn_lim;
        c.speed = 32'(sat32(speed));
        c.turn = 32'(sat32(turn));
        c.reached = 1'b0;
        expected_cmds.push_back(c);
        n_cmd++;
    endtask

    // Driver: hold the beat until accepted, then load the next one or idle.
    always @(posedge aclk) begin
        pose_beat_t nb;
        bit load_next;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                advance_pose('{s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[95:64],
                               s_tdata[127:96]});
            if (!s_tvalid || s_tready) begin
                load_next = pending_beats.size() > 0 && !hold_send &&
                            $urandom_range(0, 99) >= send_idle_pct;
                if (load_next) begin
                    nb = pending_beats.pop_front();
                    s_tdata <= {nb.ts, nb.hd, nb.py, nb.px};
                    s_tuser <= nb.kind;
                end
                s_tvalid <= load_next;
            end
        end
    end

    // Monitor: compare each result beat with the oldest expected command.
    always @(posedge aclk) begin
        command_t c;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_cmds.size() == 0) begin
                    $display("%0t: unexpected result beat %h/%b", $time, m_tdata, m_tuser);
                    errors++;
                end else begin
                    c = expected_cmds.pop_front();
                    n_checked++;
                    if (m_tdata[31:0] !== c.speed) begin
                        $display("%0t: speed_command expected %h actual %h",
                                 $time, c.speed, m_tdata[31:0]);
                        errors++;
                    end
                    if (m_tdata[63:32] !== c.turn) begin
                        $display("%0t: turn_command expected %h actual %h",
                                 $time, c.turn, m_tdata[63:32]);
                        errors++;
                    end
                    if (m_tuser !== c.reached) begin
                        $display("%0t: goal_reached expected %b actual %b",
                                 $time, c.reached, m_tuser);
                        errors++;
                    end
                end
            end
            m_tready <= $urandom_range(0, 99) >= recv_stall_pct;
        end
    end

    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) ||
                !aresetn)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("pi_pose_controller regression: fail");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic write_reg(cfg_index_t idx, bit [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_TARGET_DISTANCE: tgt_dist = longint'(signed'(val));
            REG_TARGET_ANGLE:    tgt_ang = longint'(signed'(val));
            REG_POSITION_TOL:    pos_tol = longint'(val[30:0]);
            REG_ANGLE_TOL:       ang_tol = longint'(val[30:0]);
            REG_SPEED_LIMIT:     spd_lim = longint'(signed'(val));
            REG_TURN_RATE_LIMIT: trn_lim = longint'(signed'(val));
            REG_DISTANCE_KP:     dist_kp = longint'(signed'(val));
            REG_DISTANCE_KI:     dist_ki = longint'(signed'(val));
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_beats.size() > 0 || s_tvalid || expected_cmds.size() > 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic push_beat(bit k, bit [31:0] x, bit [31:0] y, bit [31:0] h, bit [31:0] t);
        pending_beats.push_back('{k, x, y, h, t});
    endtask

    bit [31:0] phase_cfg[5][8] = '{
        '{32'd196608, 32'd32768, 32'd6554, 32'd6554, 32'd65536, 32'd65536,
          32'd65536, 32'd2000},
        '{32'hFFFE0000, 32'hFFFF0000, 32'd20000, 32'd30000, 32'h7FFFFFFF, 32'h7FFFFFFF,
          32'd200000, 32'hFFFFEC78},
        '{32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
          32'h80000000, 32'h7FFFFFFF},
        '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF0000, 32'h7FFFFFFF, 32'h80000000},
        '{32'd655360, 32'd205887, 32'd100, 32'd100, 32'd300000, 32'd300000,
          32'd65536, 32'd655}
    };
    int idle_plan[5][2] = '{'{0, 0}, '{81, 0}, '{0, 81}, '{30, 30}, '{0, 0}};

    initial begin
        int r, sel;
        longint tx, ty, th, jit;
        bit [31:0] tt;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: goal at the zero pose, 2 pi wrap both ways, extremes, restart.
        push_beat(0, 0, 0, 0, 0);
        push_beat(0, 0, 0, 32'(-TWO_PI_V), 5);
        push_beat(0, 0, 0, 32'(TWO_PI_V), 9);
        push_beat(0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
        push_beat(0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h00000010);
        push_beat(0, 32'h80000000, 32'h80000000, 32'h00030000, 32'h00001000);
        push_beat(1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        push_beat(0, 32'd1000, 32'd2000, 32'd200000, 32'd100);
        push_beat(0, 32'd3000, 32'd2500, 32'hFFFCE000, 32'd900);
        push_beat(0, 32'd5000, 32'd2600, 32'd190000, 32'd1800);
        push_beat(0, 32'd5000, 32'd2600, 32'd190000, 32'd1800);
        push_beat(1, 0, 0, 0, 0);
        wait_drained();

        for (int p = 0; p < 5; p++) begin
            write_reg(REG_TARGET_DISTANCE, phase_cfg[p][0]);
            write_reg(REG_TARGET_ANGLE,    phase_cfg[p][1]);
            write_reg(REG_POSITION_TOL,    phase_cfg[p][2]);
            write_reg(REG_ANGLE_TOL,       phase_cfg[p][3]);
            write_reg(REG_SPEED_LIMIT,     phase_cfg[p][4]);
            write_reg(REG_TURN_RATE_LIMIT, phase_cfg[p][5]);
            write_reg(REG_DISTANCE_KP,     phase_cfg[p][6]);
            write_reg(REG_DISTANCE_KI,     phase_cfg[p][7]);
            send_idle_pct = idle_plan[p][0];
            recv_stall_pct = idle_plan[p][1];
            tx = 0; ty = 0; th = 0; tt = $urandom;
            for (int i = 0; i < 255; i++) begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    push_beat(1, $urandom, $urandom, $urandom, $urandom);
                    tx = longint'($urandom_range(0, 40000)) - 20000;
                    ty = longint'($urandom_range(0, 40000)) - 20000;
                    th = 0;
                end else if (r < 14) begin
                    push_beat(0, $urandom, $urandom, $urandom, $urandom);
                end else if (r < 24) begin
                    sel = $urandom_range(0, 2);
                    jit = longint'($urandom_range(0, 200)) - 100;
                    push_beat(1, 0, 0, 0, 0);
                    push_beat(0, 32'(abs_l(tgt_dist) + jit), 32'($urandom_range(0, 50)),
                              32'(tgt_ang + jit + (sel == 0 ? 0 : sel == 1 ? TWO_PI_V
                                                               : -TWO_PI_V)),
                              $urandom);
                end else begin
                    tx += longint'($urandom_range(0, 8000)) - 2000;
                    ty += longint'($urandom_range(0, 4000)) - 2000;
                    th += longint'($urandom_range(0, 60000)) - 30000;
                    if (th > PI_V) th -= TWO_PI_V;
                    else if (th < -PI_V) th += TWO_PI_V;
                    tt += ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(1, 3000);
                    push_beat(0, 32'(tx), 32'(ty), 32'(th), tt);
                end
            end
            if (p == 1) begin
                while (pending_beats.size() > 150) @(posedge aclk);
                hold_send = 1'b1;
                while (s_tvalid || expected_cmds.size() > 0) @(posedge aclk);
                repeat ($urandom_range(5, 50)) @(posedge aclk);
                hold_send = 1'b0;
            end
            wait_drained();
        end

        $display("covered %0d command beats, %0d goal beats, %0d restarts over 5 settings",
                 n_cmd, n_goal, n_restart);
        $display("checked %0d result beats with %0d mismatches", n_checked, errors);
        if (errors == 0)
            $display("pi_pose_controller regression: pass");
        else
            $display("pi_pose_controller regression: fail");
        $finish;
    end
endmodule
